// ----- hdl/deadline_capacity_scheduler_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the deadline capacity scheduler.
// Every check is sampled on the rising clock and is disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_CAPACITY_SCHEDULER_TOP_ASSERT_SVH
`define DEADLINE_CAPACITY_SCHEDULER_TOP_ASSERT_SVH

// A property that must hold at every clock edge.
`define DCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An antecedent that must be followed by a consequent on the next edge.
`define DCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/dcs_pkg.sv -----
// ----------------------------------------------------------------------------
// dcs_pkg
// Shared constants, request and result types, and the sequencer states of
// the deadline capacity scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package dcs_pkg;

  // Heap geometry.
  localparam int HeapDepth = 1024;
  localparam int AddrW     = $clog2(HeapDepth);
  localparam int CntW      = AddrW + 1;

  // Field widths.
  localparam int TimeW  = 16;
  localparam int CapW   = 16;
  localparam int TotalW = 32;

  localparam logic [CntW-1:0] HeapFull = CntW'(HeapDepth);

  // Request mode codes.
  localparam logic [1:0] MODE_ADMIT = 2'd0;
  localparam logic [1:0] MODE_SERVE = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [TimeW-1:0] deadline;
    logic [CapW-1:0]  capacity;
    logic [TimeW-1:0] now_time;
  } req_t;

  typedef struct packed {
    logic              served;
    logic [TimeW-1:0]  served_deadline;
    logic [CapW-1:0]   left_capacity;
    logic [TotalW-1:0] served_total;
    logic              overflow_seen;
  } rsp_t;

  // Heap entry; the deadline sits on top so an unsigned compare of the whole
  // entry orders by deadline first and capacity second.
  typedef struct packed {
    logic [TimeW-1:0] dl;
    logic [CapW-1:0]  cap;
  } key_t;

  localparam int KeyW = $bits(key_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_CHK_RD,
    ST_CHK_CMP,
    ST_POP,
    ST_POP_LD,
    ST_DN_LC,
    ST_DN_RC,
    ST_DN_CMP,
    ST_RESULT
  } state_e;

endpackage

`default_nettype wire

// ----- hdl/dcs_if.sv -----
// ----------------------------------------------------------------------------
// dcs_if
// Valid/ready channels that carry scheduler requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcs_req_if;
  import dcs_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dcs_rsp_if;
  import dcs_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/dcs_ram.sv -----
// ----------------------------------------------------------------------------
// dcs_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dcs_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/deadline_capacity_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// deadline_capacity_scheduler_top: EDF heap scheduler; reset empties the heap.
// Admit sifts the new entry up one parent at a time; a full-heap admit, a
// clear and mode 3 finish in the idle state. Serve checks the root, removes
// expired or exhausted entries and sifts the last entry down, all via the
// one heap RAM port. Requests never overlap; a stalled result holds the block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "deadline_capacity_scheduler_top_assert.svh"

module deadline_capacity_scheduler_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dcs_req_if.sink   req_i,
  dcs_rsp_if.source rsp_o
);

  import dcs_pkg::*;

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [TotalW-1:0]   total_q, total_d;
  logic                ovf_q, ovf_d;
  logic                srv_q, srv_d;
  logic                rc_ok_q, rc_ok_d;
  logic                out_valid_q, out_valid_d;
  key_t                key_q, key_d;
  key_t                lc_key_q, lc_key_d;
  logic [AddrW-1:0]    pos_q, pos_d;
  logic [TimeW-1:0]    now_q, now_d;
  logic                res_did_q, res_did_d;
  logic [TimeW-1:0]    res_dl_q, res_dl_d;
  logic [CapW-1:0]     res_left_q, res_left_d;
  rsp_t                out_data_q, out_data_d;

  logic                ram_we;
  logic [AddrW-1:0]    ram_waddr;
  key_t                ram_wdata;
  logic                ram_re;
  logic [AddrW-1:0]    ram_raddr;
  logic [KeyW-1:0]     ram_rdata;
  key_t                rd_key;

  logic                in_fire;
  logic [AddrW-1:0]    parent_idx;
  logic [AddrW:0]      lc_idx;
  logic [AddrW+1:0]    rc_idx;
  logic                lc_ok;
  logic                rc_ok;
  logic [CntW-1:0]     cnt_m1;
  logic                lc_lt;
  key_t                best_key;
  logic                rc_lt;
  logic                discard;

  // Heap storage.
  dcs_ram #(
    .Width (KeyW),
    .Depth (HeapDepth)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_key = key_t'(ram_rdata);

  // Handshake signals.
  assign req_i.ready = (state_q == ST_IDLE);
  assign in_fire     = req_i.valid && req_i.ready;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_data_q;

  // Heap index arithmetic.
  assign parent_idx = (pos_q - AddrW'(1)) >> 1;
  assign lc_idx     = {pos_q, 1'b1};
  assign rc_idx     = {1'b0, lc_idx} + (AddrW+2)'(1);
  assign lc_ok      = (lc_idx < cnt_q);
  assign rc_ok      = (rc_idx < {1'b0, cnt_q});
  assign cnt_m1     = cnt_q - CntW'(1);

  // Shared compare unit for sift-down: the smallest of the moving entry and
  // its children, with ties kept on the parent side.
  assign lc_lt    = (lc_key_q < key_q);
  assign best_key = lc_lt ? lc_key_q : key_q;
  assign rc_lt    = rc_ok_q && (rd_key < best_key);

  // An expired or exhausted line at the root is removed before serving.
  assign discard = (rd_key.dl < now_q) || (rd_key.cap == '0);

  // Sequencer: next state, heap RAM control and datapath updates.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    total_d     = total_q;
    ovf_d       = ovf_q;
    srv_d       = srv_q;
    rc_ok_d     = rc_ok_q;
    out_valid_d = out_valid_q;
    key_d       = key_q;
    lc_key_d    = lc_key_q;
    pos_d       = pos_q;
    now_d       = now_q;
    res_did_d   = res_did_q;
    res_dl_d    = res_dl_q;
    res_left_d  = res_left_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = pos_q;
    ram_wdata   = key_q;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (req_i.data.mode)
            MODE_ADMIT: begin
              if (cnt_q == HeapFull) begin
                ovf_d = 1'b1;
              end else begin
                key_d   = '{dl: req_i.data.deadline, cap: req_i.data.capacity};
                pos_d   = cnt_q[AddrW-1:0];
                cnt_d   = cnt_q + CntW'(1);
                state_d = ST_UP_RD;
              end
            end
            MODE_SERVE: begin
              now_d      = req_i.data.now_time;
              res_did_d  = 1'b0;
              res_dl_d   = '0;
              res_left_d = '0;
              state_d    = ST_CHK_RD;
            end
            MODE_CLEAR: begin
              cnt_d   = '0;
              total_d = '0;
              ovf_d   = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      // Sift-up: read the parent of the hole.
      ST_UP_RD: begin
        if (pos_q == '0) begin
          ram_we  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = parent_idx;
          state_d   = ST_UP_CMP;
        end
      end

      // Sift-up: move the parent down or settle the new entry.
      ST_UP_CMP: begin
        ram_we = 1'b1;
        if (key_q < rd_key) begin
          ram_wdata = rd_key;
          pos_d     = parent_idx;
          state_d   = ST_UP_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end

      // Serve: look at the root.
      ST_CHK_RD: begin
        if (cnt_q == '0) begin
          state_d = ST_RESULT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = '0;
          state_d   = ST_CHK_CMP;
        end
      end

      ST_CHK_CMP: begin
        if (discard) begin
          srv_d   = 1'b0;
          state_d = ST_POP;
        end else begin
          res_did_d  = 1'b1;
          res_dl_d   = rd_key.dl;
          res_left_d = rd_key.cap - CapW'(1);
          if (total_q != '1) begin
            total_d = total_q + TotalW'(1);
          end
          if (rd_key.cap == CapW'(1)) begin
            srv_d   = 1'b1;
            state_d = ST_POP;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = '{dl: rd_key.dl, cap: rd_key.cap - CapW'(1)};
            state_d   = ST_RESULT;
          end
        end
      end

      // Pop: shrink the heap and fetch the last entry for the root.
      ST_POP: begin
        cnt_d = cnt_m1;
        if (cnt_m1 == '0) begin
          state_d = srv_q ? ST_RESULT : ST_CHK_RD;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = cnt_m1[AddrW-1:0];
          state_d   = ST_POP_LD;
        end
      end

      ST_POP_LD: begin
        key_d   = rd_key;
        pos_d   = '0;
        state_d = ST_DN_LC;
      end

      // Sift-down: fetch the left child, or settle when there is none.
      ST_DN_LC: begin
        if (lc_ok) begin
          ram_re    = 1'b1;
          ram_raddr = lc_idx[AddrW-1:0];
          state_d   = ST_DN_RC;
        end else begin
          ram_we  = 1'b1;
          state_d = srv_q ? ST_RESULT : ST_CHK_RD;
        end
      end

      // Sift-down: keep the left child and fetch the right one if present.
      ST_DN_RC: begin
        lc_key_d = rd_key;
        rc_ok_d  = rc_ok;
        if (rc_ok) begin
          ram_re    = 1'b1;
          ram_raddr = rc_idx[AddrW-1:0];
        end
        state_d = ST_DN_CMP;
      end

      // Sift-down: move the smaller child up or settle the entry.
      ST_DN_CMP: begin
        ram_we = 1'b1;
        if (rc_lt) begin
          ram_wdata = rd_key;
          pos_d     = rc_idx[AddrW-1:0];
          state_d   = ST_DN_LC;
        end else if (lc_lt) begin
          ram_wdata = lc_key_q;
          pos_d     = lc_idx[AddrW-1:0];
          state_d   = ST_DN_LC;
        end else begin
          state_d = srv_q ? ST_RESULT : ST_CHK_RD;
        end
      end

      // Hand the result to the output register once it is free.
      ST_RESULT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_data_d = '{
            served:          res_did_q,
            served_deadline: res_dl_q,
            left_capacity:   res_left_q,
            served_total:    total_q,
            overflow_seen:   ovf_q
          };
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      srv_q       <= 1'b0;
      rc_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      total_q     <= total_d;
      ovf_q       <= ovf_d;
      srv_q       <= srv_d;
      rc_ok_q     <= rc_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    lc_key_q   <= lc_key_d;
    pos_q      <= pos_d;
    now_q      <= now_d;
    res_did_q  <= res_did_d;
    res_dl_q   <= res_dl_d;
    res_left_q <= res_left_d;
    out_data_q <= out_data_d;
  end

  // The heap never holds more entries than it has room for.
  `DCS_ASSERT(a_cnt_bound, cnt_q <= HeapFull, "heap count exceeds depth")

  // Every heap write lands inside the occupied part of the heap.
  `DCS_ASSERT(a_write_in_heap, !ram_we || ({1'b0, ram_waddr} < cnt_q),
              "heap write outside the occupied entries")

  // The served total only steps by one or returns to zero on a clear.
  `DCS_ASSERT(a_total_step,
              (total_q == $past(total_q)) || (total_q == $past(total_q) + TotalW'(1)) ||
              (total_q == '0), "served total moved by more than one")

  // The overflow flag rises only when an admit met a full heap.
  `DCS_ASSERT(a_ovf_rise, !$rose(ovf_q) || ($past(cnt_q) == HeapFull),
              "overflow set while the heap had room")

  // An admit into a heap with room grows it by exactly one entry.
  `DCS_ASSERT_NEXT(a_admit_grows,
                   in_fire && (req_i.data.mode == MODE_ADMIT) && (cnt_q != HeapFull),
                   cnt_q == $past(cnt_q) + CntW'(1), "admit did not add one entry")

endmodule

`default_nettype wire

// ----- tb/tb_deadline_capacity_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// tb_deadline_capacity_scheduler_top
// Self-checking bench for the earliest-deadline-first heap scheduler. A queue
// of requests (directed corner cases, one heap fill past capacity, then
// random admit/serve rounds mixed with clears and noise) feeds a bursty
// driver. A behavioral heap model predicts every serve result, and a monitor
// compares each accepted result field by field while the result side stalls
// on a changing pattern.
// ----------------------------------------------------------------------------
module tb_deadline_capacity_scheduler_top;
  import dcs_pkg::*;

  localparam int unsigned ClkHalf       = 6;
  localparam int unsigned ResetCycles   = 4;
  localparam int unsigned ItemsTarget   = 1550;
  localparam int unsigned TimeoutCycles = 1_500_000;
  localparam int unsigned DrainCycles   = 60;

  // Mode 3 is not decoded by the block and must be ignored.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    req_t req;
    bit   drain_first;
  } stim_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dcs_req_if req_if ();
  dcs_rsp_if rsp_if ();

  deadline_capacity_scheduler_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // Pending requests, and the serve results the heap model has predicted.
  stim_item_t request_q[$];
  rsp_t       slot_results_q[$];
  int unsigned stim_count = 0;

  // Heap model state.
  key_t        edf_heap [HeapDepth];
  int unsigned heap_len = 0;
  logic [TotalW-1:0] served_sum = '0;
  bit          overflow_hit = 1'b0;

  // Coverage tallies.
  int unsigned n_admit = 0, n_dropped = 0, n_hit = 0, n_empty = 0;
  int unsigned n_clear = 0, n_ignored = 0, peak_len = 0, n_checked = 0;
  int unsigned mismatch_count = 0;

  // Driver and receiver state.
  bit          req_fire = 1'b0;
  int unsigned burst_left = 0, gap_left = 0;
  logic [15:0] ready_mask = '1;
  logic [3:0]  ready_phase = '0;
  int unsigned mask_left = 0;
  stim_item_t  head_item;

  // --------------------------------------------------------------------------
  // Heap model
  // --------------------------------------------------------------------------

  // Earlier deadline first; on equal deadlines the smaller capacity wins.
  function automatic bit line_precedes(key_t a, key_t b);
    return {a.dl, a.cap} < {b.dl, b.cap};
  endfunction

  function automatic void heap_swap(int unsigned a, int unsigned b);
    key_t t;
    t = edf_heap[a];
    edf_heap[a] = edf_heap[b];
    edf_heap[b] = t;
  endfunction

  function automatic void heap_insert(key_t k);
    int unsigned pos, parent;
    edf_heap[heap_len] = k;
    pos = heap_len;
    heap_len++;
    while (pos > 0) begin
      parent = (pos - 1) / 2;
      if (!line_precedes(edf_heap[pos], edf_heap[parent])) break;
      heap_swap(pos, parent);
      pos = parent;
    end
  endfunction

  function automatic void heap_remove_top();
    int unsigned pos, best, lc, rc;
    if (heap_len == 0) return;
    heap_len--;
    if (heap_len == 0) return;
    edf_heap[0] = edf_heap[heap_len];
    pos = 0;
    forever begin
      best = pos;
      lc = 2 * pos + 1;
      rc = lc + 1;
      if (lc < heap_len && line_precedes(edf_heap[lc], edf_heap[best])) best = lc;
      if (rc < heap_len && line_precedes(edf_heap[rc], edf_heap[best])) best = rc;
      if (best == pos) break;
      heap_swap(pos, best);
      pos = best;
    end
  endfunction

  // Apply one accepted request to the model; a serve queues its result.
  function automatic void apply_to_schedule(req_t r);
    rsp_t want;
    key_t k;
    case (r.mode)
      MODE_ADMIT: begin
        n_admit++;
        if (heap_len >= HeapDepth) begin
          overflow_hit = 1'b1;
          n_dropped++;
        end else begin
          k.dl  = r.deadline;
          k.cap = r.capacity;
          heap_insert(k);
          if (heap_len > peak_len) peak_len = heap_len;
        end
      end
      MODE_SERVE: begin
        // Expired lines and lines without capacity leave the top first.
        while (heap_len > 0 && (edf_heap[0].dl < r.now_time || edf_heap[0].cap == 0))
          heap_remove_top();
        want = '0;
        if (heap_len > 0) begin
          want.served          = 1'b1;
          want.served_deadline = edf_heap[0].dl;
          want.left_capacity   = edf_heap[0].cap - CapW'(1);
          edf_heap[0].cap      = want.left_capacity;
          if (want.left_capacity == 0) heap_remove_top();
          if (served_sum != '1) served_sum++;
          n_hit++;
        end else begin
          n_empty++;
        end
        want.served_total  = served_sum;
        want.overflow_seen = overflow_hit;
        slot_results_q.push_back(want);
      end
      MODE_CLEAR: begin
        heap_len     = 0;
        served_sum   = '0;
        overflow_hit = 1'b0;
        n_clear++;
      end
      default: n_ignored++;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------

  function automatic void queue_request(logic [1:0] mode, logic [TimeW-1:0] dl,
                                        logic [CapW-1:0] cap, logic [TimeW-1:0] slot,
                                        bit drain);
    stim_item_t it;
    it.req.mode     = mode;
    it.req.deadline = dl;
    it.req.capacity = cap;
    it.req.now_time = slot;
    it.drain_first  = drain;
    request_q.push_back(it);
    if (mode != MODE_UNUSED) stim_count++;
  endfunction

  function automatic logic [CapW-1:0] pick_capacity();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom_range(0, 1) ? '1 : CapW'($urandom);
      default: return CapW'($urandom_range(1, 4));
    endcase
  endfunction

  // One stretch of consecutive slots: a few admits due soon, then the serve.
  function automatic void add_slot_round();
    int slot_time, dl;
    int unsigned slots;
    case ($urandom_range(0, 3))
      0:       slot_time = $urandom_range(0, 20);
      1:       slot_time = $urandom_range(65500, 65535);
      default: slot_time = $urandom_range(0, 65535);
    endcase
    slots = $urandom_range(4, 20);
    repeat (slots) begin
      repeat ($urandom_range(0, 3)) begin
        dl = slot_time + $urandom_range(0, 24) - 4;
        if (dl < 0) dl = 0;
        if (dl > 65535) dl = 65535;
        queue_request(MODE_ADMIT, TimeW'(dl), pick_capacity(), TimeW'($urandom), 1'b0);
      end
      queue_request(MODE_SERVE, TimeW'($urandom), CapW'($urandom), TimeW'(slot_time), 1'b0);
      slot_time = slot_time + $urandom_range(0, 3);
      if (slot_time > 65535) slot_time = 65535;
    end
  endfunction

  // Fill the heap past its depth, serve across the time range, then clear.
  function automatic void add_full_heap_round();
    int slot_time;
    queue_request(MODE_CLEAR, TimeW'($urandom), CapW'($urandom), TimeW'($urandom), 1'b1);
    repeat (HeapDepth + 4) begin
      queue_request(MODE_ADMIT, TimeW'($urandom),
                    $urandom_range(0, 4) == 0 ? CapW'($urandom) : CapW'($urandom_range(0, 3)),
                    TimeW'($urandom), 1'b0);
    end
    slot_time = 0;
    queue_request(MODE_SERVE, TimeW'($urandom), CapW'($urandom), TimeW'(slot_time), 1'b1);
    repeat (24) begin
      slot_time = slot_time + $urandom_range(0, 4000);
      if (slot_time > 65535) slot_time = 65535;
      queue_request(MODE_SERVE, TimeW'($urandom), CapW'($urandom), TimeW'(slot_time), 1'b0);
    end
    queue_request(MODE_CLEAR, TimeW'($urandom), CapW'($urandom), TimeW'($urandom), 1'b0);
  endfunction

  // --------------------------------------------------------------------------
  // Request driver and result-side ready pattern, both on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      rsp_if.ready <= 1'b0;
    end else begin
      // Present the next request once the current one is gone.
      if (!req_if.valid || req_fire) begin
        if (gap_left != 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (request_q.size() != 0 &&
                     !(request_q[0].drain_first && slot_results_q.size() != 0)) begin
          head_item = request_q.pop_front();
          req_if.valid <= 1'b1;
          req_if.data  <= head_item.req;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end else begin
            burst_left--;
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end

      // The ready pattern is replaced whenever its countdown runs out.
      if (mask_left == 0) begin
        mask_left = $urandom_range(40, 300);
        case ($urandom_range(0, 2))
          0:       ready_mask = '1;
          1:       ready_mask = 16'($urandom) | 16'h1;
          default: ready_mask = 16'($urandom & $urandom) | 16'h1;
        endcase
      end else begin
        mask_left--;
      end
      ready_phase = ready_phase + 4'd1;
      rsp_if.ready <= ready_mask[ready_phase];
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check results, then feed accepted requests to the model
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [TotalW-1:0] got,
                                 logic [TotalW-1:0] want);
    $display("MISMATCH at %0t: %s got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    rsp_t want, got;
    if (!rst_ni) begin
      req_fire = 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.data;
        n_checked++;
        if (slot_results_q.size() == 0) begin
          report_mismatch("result with nothing pending, total", got.served_total, '0);
        end else begin
          want = slot_results_q.pop_front();
          if (got.served !== want.served)
            report_mismatch("served", TotalW'(got.served), TotalW'(want.served));
          if (got.served_deadline !== want.served_deadline)
            report_mismatch("served_deadline", TotalW'(got.served_deadline),
                            TotalW'(want.served_deadline));
          if (got.left_capacity !== want.left_capacity)
            report_mismatch("left_capacity", TotalW'(got.left_capacity),
                            TotalW'(want.left_capacity));
          if (got.served_total !== want.served_total)
            report_mismatch("served_total", got.served_total, want.served_total);
          if (got.overflow_seen !== want.overflow_seen)
            report_mismatch("overflow_seen", TotalW'(got.overflow_seen),
                            TotalW'(want.overflow_seen));
        end
      end
      req_fire = req_if.valid && req_if.ready;
      if (req_fire) apply_to_schedule(req_if.data);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;

    // Directed corner cases.
    queue_request(MODE_SERVE, '1, '1, '0, 1'b0);           // empty heap
    queue_request(MODE_UNUSED, '1, '1, '1, 1'b0);
    queue_request(MODE_ADMIT, '1, '1, '0, 1'b0);
    queue_request(MODE_ADMIT, '0, 16'd1, '1, 1'b0);
    queue_request(MODE_ADMIT, 16'd100, '0, '0, 1'b0);      // zero capacity
    queue_request(MODE_ADMIT, 16'd100, 16'd2, '0, 1'b0);
    queue_request(MODE_ADMIT, 16'd100, 16'd1, '0, 1'b0);   // tie on deadline
    queue_request(MODE_SERVE, '0, '0, '0, 1'b0);
    queue_request(MODE_SERVE, '0, '0, 16'd50, 1'b0);
    queue_request(MODE_SERVE, '0, '0, 16'd100, 1'b0);
    queue_request(MODE_SERVE, '0, '0, 16'd101, 1'b0);      // expired line dropped
    queue_request(MODE_SERVE, '0, '0, '1, 1'b0);
    queue_request(MODE_UNUSED, '0, '0, '0, 1'b0);
    queue_request(MODE_CLEAR, '0, '0, '0, 1'b1);
    queue_request(MODE_SERVE, '0, '0, '1, 1'b0);
    queue_request(MODE_ADMIT, '0, '0, '0, 1'b0);
    queue_request(MODE_SERVE, '1, '1, '0, 1'b0);

    // Random part, beginning with one pass past a full heap.
    add_full_heap_round();
    while (stim_count < ItemsTarget) begin
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 4))
            queue_request(2'($urandom_range(0, 3)), TimeW'($urandom), CapW'($urandom),
                          TimeW'($urandom), 1'b0);
        end
        1:       queue_request(MODE_CLEAR, TimeW'($urandom), CapW'($urandom),
                               TimeW'($urandom), 1'($urandom_range(0, 1)));
        default: add_slot_round();
      endcase
    end

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Let everything drain, then allow the tail of the last request to finish.
    while (request_q.size() != 0 || req_if.valid) @(posedge clk_i);
    while (slot_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d admits (%0d dropped on a full heap, peak %0d lines), %0d clears,",
             n_admit, n_dropped, peak_len, n_clear);
    $display("%0d serves (%0d served a line, %0d found none), %0d ignored; %0d mismatches.",
             n_hit + n_empty, n_hit, n_empty, n_ignored, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(2 * ClkHalf * TimeoutCycles);
    $display("Timeout: %0d requests and %0d results still pending",
             request_q.size(), slot_results_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
